>>> hdl/asmc_pkg.sv
package asmc_pkg;

    localparam int unsigned DataW = 32;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 31;

    localparam logic signed [DataW-1:0] PiQ16 = 32'sd205887;
    localparam logic signed [DataW-1:0] TwoPiQ16 = 32'sd411775;

    localparam logic [16:0] SamplePeriodRst = 17'd655;
    localparam logic [30:0] OneQ16Rst = 31'd65536;
    localparam logic [30:0] SmallQ16Rst = 31'd6554;

    typedef enum logic [CfgIdxW-1:0] {
        REG_SAMPLE_PERIOD = 3'd0,
        REG_SURFACE_SLOPE = 3'd1,
        REG_LINEAR_GAIN   = 3'd2,
        REG_ADAPT_RATE    = 3'd3,
        REG_INITIAL_GAIN  = 3'd4,
        REG_GAIN_FLOOR    = 3'd5,
        REG_SURFACE_BAND  = 3'd6,
        REG_ANGULAR_MODE  = 3'd7
    } t_reg_idx;

    localparam logic REQ_STEP  = 1'b0;
    localparam logic REQ_RESET = 1'b1;

    typedef struct packed {
        logic                    req_type;
        logic signed [DataW-1:0] position;
        logic signed [DataW-1:0] velocity;
        logic signed [DataW-1:0] position_target;
        logic signed [DataW-1:0] velocity_target;
    } t_in_item;

    typedef struct packed {
        logic signed [DataW-1:0] control_out;
        logic signed [DataW-1:0] surface_value;
        logic signed [DataW-1:0] adaptive_gain;
    } t_out_item;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [DataW-1:0] sat32(input logic signed [65:0] x);
        logic signed [DataW-1:0] r;
        if (x > 66'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < -66'sh0_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[DataW-1:0];
        end
        return r;
    endfunction

    // shift right with rounding, ties away from zero
    function automatic logic signed [65:0] shr_rnd(input logic signed [65:0] p,
                                                   input logic [4:0] sh);
        logic [65:0] m;
        logic [65:0] half;
        m = p[65] ? 66'(-p) : 66'(p);
        half = 66'd1 << (sh - 5'd1);
        m = (m + half) >> sh;
        return p[65] ? -$signed(m) : $signed(m);
    endfunction

endpackage

>>> hdl/adaptive_sliding_mode_control_step_core.sv
// Adaptive sliding-mode controller step, signed Q16.16. A control request
// runs a small sequencer that uses one shared 33x33 signed multiplier four
// times (lambda*e1, (rate+previous rate)*T, K2*s, K1*sqrt|s|), and a bit-pair
// square-root unit runs 24 iterations of one restoring step each. A reset
// request gives its result on the next cycle. Input ready is low from
// acceptance until the result register is empty again; the result holds
// until the downstream side takes it, so no new request is taken before
// the result is taken. Configuration writes are taken at any edge with
// write enable high; a write of initial_gain also loads K1.
module adaptive_sliding_mode_control_step_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [asmc_pkg::CfgIdxW-1:0]        i_cfg_idx,
    input  logic [asmc_pkg::CfgDataW-1:0]       i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  asmc_pkg::t_in_item                  i_data,
    output logic                                o_valid,
    input  logic                                i_ready,
    output asmc_pkg::t_out_item                 o_data
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_ERR, ST_MUL_S, ST_SURF, ST_RATE, ST_MUL_K, ST_GAIN,
        ST_MUL_L, ST_SQRT, ST_MUL_U, ST_DONE, ST_OUT
    } t_state;

    t_state r_state;
    logic [16:0] r_t;
    logic [30:0] r_lambda, r_k2, r_ka, r_kmin, r_mu;
    logic        r_ang;
    logic signed [31:0] r_gain, r_rate;
    logic signed [31:0] r_e1, r_e2, r_s;
    logic signed [47:0] r_lin;
    logic signed [32:0] r_ma, r_mb;
    logic signed [65:0] r_prod;
    logic [47:0] r_rem;
    logic [24:0] r_root;
    logic [4:0]  r_cnt;
    asmc_pkg::t_out_item r_out;
    logic        r_ov;

    logic signed [32:0] w_d1, w_d2;
    logic signed [31:0] w_e1, w_e2, w_rate;
    logic [31:0] w_sabs;
    logic [26:0] w_trial;

    function automatic logic signed [31:0] wrap(input logic signed [32:0] e,
                                                input logic ang);
        logic signed [34:0] x;
        x = 35'(e);
        if (ang) begin
            if (x > 35'(asmc_pkg::PiQ16)) begin
                x = x - 35'(asmc_pkg::TwoPiQ16);
            end else if (x < -35'(asmc_pkg::PiQ16)) begin
                x = x + 35'(asmc_pkg::TwoPiQ16);
            end
        end
        return asmc_pkg::sat32(66'(x));
    endfunction

    assign w_d1 = 33'(i_data.position_target) - 33'(i_data.position);
    assign w_d2 = 33'(i_data.velocity_target) - 33'(i_data.velocity);
    assign w_e1 = wrap(w_d1, r_ang);
    assign w_e2 = wrap(w_d2, r_ang);
    // magnitude is unsigned so that the most negative surface stays exact
    assign w_sabs = r_s[31] ? 32'(-r_s) : 32'(r_s);

    always_comb begin
        if (r_gain > $signed({1'b0, r_kmin})) begin
            if (w_sabs > {1'b0, r_mu}) begin
                w_rate = $signed({1'b0, r_ka});
            end else if (w_sabs < {1'b0, r_mu}) begin
                w_rate = -$signed({1'b0, r_ka});
            end else begin
                w_rate = '0;
            end
        end else begin
            w_rate = $signed({1'b0, r_kmin});
        end
    end

    // one restoring square-root step, two radicand bits a cycle
    assign w_trial = {r_root, 2'b01};

    assign o_ready = (r_state == ST_IDLE) && !r_ov;
    assign o_valid = r_ov;
    assign o_data = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov <= 1'b0;
            r_t <= asmc_pkg::SamplePeriodRst;
            r_lambda <= asmc_pkg::OneQ16Rst;
            r_k2 <= asmc_pkg::OneQ16Rst;
            r_ka <= asmc_pkg::OneQ16Rst;
            r_kmin <= asmc_pkg::SmallQ16Rst;
            r_mu <= asmc_pkg::SmallQ16Rst;
            r_ang <= 1'b0;
            r_gain <= 32'(asmc_pkg::OneQ16Rst);
            r_rate <= '0;
        end else begin
            r_prod <= r_ma * r_mb;
            if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (asmc_pkg::t_reg_idx'(i_cfg_idx))
                    asmc_pkg::REG_SAMPLE_PERIOD: r_t <= i_cfg_data[16:0];
                    asmc_pkg::REG_SURFACE_SLOPE: r_lambda <= i_cfg_data;
                    asmc_pkg::REG_LINEAR_GAIN:   r_k2 <= i_cfg_data;
                    asmc_pkg::REG_ADAPT_RATE:    r_ka <= i_cfg_data;
                    asmc_pkg::REG_INITIAL_GAIN:  r_gain <= {1'b0, i_cfg_data};
                    asmc_pkg::REG_GAIN_FLOOR:    r_kmin <= i_cfg_data;
                    asmc_pkg::REG_SURFACE_BAND:  r_mu <= i_cfg_data;
                    asmc_pkg::REG_ANGULAR_MODE:  r_ang <= i_cfg_data[0];
                    default: ;
                endcase
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid && o_ready) begin
                        if (i_data.req_type == asmc_pkg::REQ_RESET) begin
                            r_gain <= '0;
                            r_out <= '0;
                            r_ov <= 1'b1;
                        end else begin
                            r_e1 <= w_e1;
                            r_e2 <= w_e2;
                            r_state <= ST_ERR;
                        end
                    end
                end
                ST_ERR: begin
                    r_ma <= {2'b00, r_lambda};
                    r_mb <= 33'(r_e1);
                    r_state <= ST_MUL_S;
                end
                ST_MUL_S: r_state <= ST_SURF;
                ST_SURF: begin
                    r_s <= asmc_pkg::sat32(66'(r_e2) + asmc_pkg::shr_rnd(r_prod, 5'd16));
                    r_state <= ST_RATE;
                end
                ST_RATE: begin
                    r_ma <= 33'(w_rate) + 33'(r_rate);
                    r_mb <= {16'd0, r_t};
                    r_rate <= w_rate;
                    r_rem <= {w_sabs, 16'd0};
                    r_cnt <= '0;
                    r_state <= ST_MUL_K;
                end
                ST_MUL_K: r_state <= ST_GAIN;
                ST_GAIN: begin
                    r_gain <= asmc_pkg::sat32(66'(r_gain)
                                              + asmc_pkg::shr_rnd(r_prod, 5'd17));
                    r_ma <= {2'b00, r_k2};
                    r_mb <= 33'(r_s);
                    r_state <= ST_MUL_L;
                end
                ST_MUL_L: begin
                    r_state <= ST_SQRT;
                end
                ST_SQRT: begin
                    if (r_cnt == 5'd0) begin
                        r_lin <= 48'(asmc_pkg::shr_rnd(r_prod, 5'd16));
                    end
                    // shift the radicand out two bits a cycle
                    r_rem <= {r_rem[45:0], 2'b00};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd23) begin
                        r_state <= ST_MUL_U;
                    end
                end
                ST_MUL_U: begin
                    r_ma <= 33'(r_gain);
                    r_mb <= {8'd0, r_root};
                    r_state <= ST_DONE;
                end
                ST_DONE: r_state <= ST_OUT;
                ST_OUT: begin
                    r_out.control_out <= asmc_pkg::sat32(
                        ((r_s == 0) ? 66'sd0 :
                         (r_s[31] ? asmc_pkg::shr_rnd(r_prod, 5'd16)
                                  : -asmc_pkg::shr_rnd(r_prod, 5'd16)))
                        - 66'(r_lin));
                    r_out.surface_value <= r_s;
                    r_out.adaptive_gain <= r_gain;
                    r_cnt <= '0;
                    r_ov <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // square-root remainder and root
    logic [26:0] r_sqr;
    logic [26:0] w_cand;
    assign w_cand = {r_sqr[24:0], r_rem[47:46]};
    always_ff @(posedge i_clk) begin
        if (r_state == ST_RATE) begin
            r_sqr <= '0;
            r_root <= '0;
        end else if (r_state == ST_SQRT) begin
            if (w_cand >= w_trial) begin
                r_sqr <= w_cand - w_trial;
                r_root <= {r_root[23:0], 1'b1};
            end else begin
                r_sqr <= w_cand;
                r_root <= {r_root[23:0], 1'b0};
            end
        end
    end

    a_no_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_ready) else $error("ready while busy");
    a_out_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |=> o_valid) else $error("no result after step");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_data)))
        else $error("result dropped");

endmodule

>>> dv/asmc_step_checker.sv
`timescale 1ns / 100ps

module asmc_step_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [asmc_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [asmc_pkg::CfgDataW-1:0]  i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  asmc_pkg::t_in_item             i_in_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  asmc_pkg::t_out_item            i_out_data,
    output int                             o_fail_count,
    output int                             o_pending
);

    localparam longint PiFix = 205887;
    localparam longint TwoPiFix = 411775;
    localparam longint MaxS32 = 64'sd2147483647;
    localparam longint MinS32 = -64'sd2147483648;

    logic [16:0] period_q;
    logic [30:0] slope_q, k2_q, alpha_q, k1_init_q, kmin_q, band_q;
    logic        wrap_en_q;
    longint      k1_q, rate_prev_q;

    asmc_pkg::t_out_item expected_results[$];
    int          fails;

    assign o_fail_count = fails;

    function automatic longint clamp32(longint x);
        if (x > MaxS32) return MaxS32;
        if (x < MinS32) return MinS32;
        return x;
    endfunction

    // round to nearest, ties away from zero
    function automatic longint round_shift(longint p, int sh);
        longint m;
        m = (p < 0) ? -p : p;
        m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
        return (p < 0) ? -m : m;
    endfunction

    function automatic longint int_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint fold_error(longint e);
        if (wrap_en_q) begin
            if (e > PiFix) e = e - TwoPiFix;
            else if (e < -PiFix) e = e + TwoPiFix;
        end
        return clamp32(e);
    endfunction

    // advance the controller state by one request and give its result
    function automatic asmc_pkg::t_out_item control_step(asmc_pkg::t_in_item req);
        asmc_pkg::t_out_item res;
        longint    e1, e2, s, sabs, rate, k1, u, root;
        if (req.req_type == asmc_pkg::REQ_RESET) begin
            k1_q = 0;
            res = '0;
            return res;
        end
        e1 = fold_error(longint'(req.position_target) - longint'(req.position));
        e2 = fold_error(longint'(req.velocity_target) - longint'(req.velocity));
        s = clamp32(e2 + round_shift(longint'(slope_q) * e1, 16));
        sabs = (s < 0) ? -s : s;
        if (k1_q > longint'(kmin_q)) begin
            if (sabs > longint'(band_q)) rate = longint'(alpha_q);
            else if (sabs < longint'(band_q)) rate = -longint'(alpha_q);
            else rate = 0;
        end else begin
            rate = longint'(kmin_q);
        end
        k1 = clamp32(k1_q + round_shift((rate + rate_prev_q) * longint'(period_q), 17));
        k1_q = k1;
        rate_prev_q = rate;
        root = int_sqrt(longint'(sabs) <<< 16);
        u = round_shift(k1 * root, 16);
        if (s < 0) u = -u;
        else if (s == 0) u = 0;
        u = clamp32(-u - round_shift(longint'(k2_q) * s, 16));
        res.control_out   = u[31:0];
        res.surface_value = s[31:0];
        res.adaptive_gain = k1[31:0];
        return res;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        fails++;
        $display("%0t mismatch %s: got %0d expected %0d", $time, what,
                 $signed(got), $signed(want));
    endtask

    initial begin
        fails = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        asmc_pkg::t_out_item want;
        if (!i_rst_n) begin
            period_q    <= asmc_pkg::SamplePeriodRst;
            slope_q     <= asmc_pkg::OneQ16Rst;
            k2_q        <= asmc_pkg::OneQ16Rst;
            alpha_q     <= asmc_pkg::OneQ16Rst;
            k1_init_q   <= asmc_pkg::OneQ16Rst;
            kmin_q      <= asmc_pkg::SmallQ16Rst;
            band_q      <= asmc_pkg::SmallQ16Rst;
            wrap_en_q   <= 1'b0;
            k1_q        = longint'(asmc_pkg::OneQ16Rst);
            rate_prev_q = 0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (asmc_pkg::t_reg_idx'(i_cfg_idx))
                    asmc_pkg::REG_SAMPLE_PERIOD: period_q <= i_cfg_data[16:0];
                    asmc_pkg::REG_SURFACE_SLOPE: slope_q <= i_cfg_data;
                    asmc_pkg::REG_LINEAR_GAIN:   k2_q <= i_cfg_data;
                    asmc_pkg::REG_ADAPT_RATE:    alpha_q <= i_cfg_data;
                    asmc_pkg::REG_INITIAL_GAIN: begin
                        k1_init_q <= i_cfg_data;
                        k1_q = longint'(i_cfg_data);
                    end
                    asmc_pkg::REG_GAIN_FLOOR:    kmin_q <= i_cfg_data;
                    asmc_pkg::REG_SURFACE_BAND:  band_q <= i_cfg_data;
                    asmc_pkg::REG_ANGULAR_MODE:  wrap_en_q <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                expected_results.push_back(control_step(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report("unexpected result", i_out_data.control_out, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_data.control_out !== want.control_out)
                        report("control_out", i_out_data.control_out, want.control_out);
                    if (i_out_data.surface_value !== want.surface_value)
                        report("surface_value", i_out_data.surface_value,
                               want.surface_value);
                    if (i_out_data.adaptive_gain !== want.adaptive_gain)
                        report("adaptive_gain", i_out_data.adaptive_gain,
                               want.adaptive_gain);
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [asmc_pkg::CfgIdxW-1:0]  i_cfg_idx;
    logic [asmc_pkg::CfgDataW-1:0] i_cfg_data;
    logic                          i_valid;
    logic                          o_ready;
    asmc_pkg::t_in_item            i_data;
    logic                          o_valid;
    logic                          i_ready;
    asmc_pkg::t_out_item           o_data;
    int                            fail_count;
    int                            pending;
    bit                            no_gaps;

    adaptive_sliding_mode_control_step_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data)
    );

    asmc_step_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_data    (i_data),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_data   (o_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    initial begin
        #10_000_000;
        $display("tb NOT OK");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(20, 70);
    endfunction

    // downstream side: random stalls, one long hold-off to back the block up
    initial begin
        int cyc;
        int stall;
        i_ready = 1'b0;
        cyc = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            cyc++;
            if (cyc == 3000) begin
                i_ready = 1'b0;
                repeat (600) @(negedge i_clk);
            end
            stall = pick_gap();
            if (stall > 0) begin
                i_ready = 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end else begin
                i_ready = 1'b1;
            end
        end
    end

    task automatic write_reg(asmc_pkg::t_reg_idx idx, logic [asmc_pkg::CfgDataW-1:0] val);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    task automatic write_all(logic [asmc_pkg::CfgDataW-1:0] t,
                             logic [asmc_pkg::CfgDataW-1:0] lam,
                             logic [asmc_pkg::CfgDataW-1:0] k2,
                             logic [asmc_pkg::CfgDataW-1:0] ka,
                             logic [asmc_pkg::CfgDataW-1:0] k1,
                             logic [asmc_pkg::CfgDataW-1:0] kmin,
                             logic [asmc_pkg::CfgDataW-1:0] mu,
                             logic [asmc_pkg::CfgDataW-1:0] ang);
        write_reg(asmc_pkg::REG_SAMPLE_PERIOD, t);
        write_reg(asmc_pkg::REG_SURFACE_SLOPE, lam);
        write_reg(asmc_pkg::REG_LINEAR_GAIN, k2);
        write_reg(asmc_pkg::REG_ADAPT_RATE, ka);
        write_reg(asmc_pkg::REG_INITIAL_GAIN, k1);
        write_reg(asmc_pkg::REG_GAIN_FLOOR, kmin);
        write_reg(asmc_pkg::REG_SURFACE_BAND, mu);
        write_reg(asmc_pkg::REG_ANGULAR_MODE, ang);
    endtask

    // hold until every result is back, then let the pipeline drain
    task automatic drain();
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    // offer one request; valid stays up if the next follows without a gap
    task automatic send_req(asmc_pkg::t_in_item req);
        int gap;
        i_valid = 1'b1;
        i_data  = req;
        #1;
        while (!o_ready) begin
            @(negedge i_clk);
            #1;
        end
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    function automatic asmc_pkg::t_in_item mk_req(logic kind, int p, int v, int pt, int vt);
        asmc_pkg::t_in_item r;
        r.req_type        = kind;
        r.position        = p;
        r.velocity        = v;
        r.position_target = pt;
        r.velocity_target = vt;
        return r;
    endfunction

    function automatic int jitter(int c, int span);
        return c + int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic asmc_pkg::t_in_item rand_req();
        int r;
        int pt;
        int vt;
        r = $urandom_range(0, 99);
        if (r < 5)
            return mk_req(asmc_pkg::REQ_RESET, $urandom, $urandom, $urandom, $urandom);
        if (r < 30)
            return mk_req(asmc_pkg::REQ_STEP, $urandom, $urandom, $urandom, $urandom);
        pt = jitter(0, 1 << 19);
        vt = jitter(0, 1 << 18);
        // errors mostly near the band and around pi
        return mk_req(asmc_pkg::REQ_STEP, jitter(pt, (r < 65) ? 8192 : 400000),
                      jitter(vt, 8192), pt, vt);
    endfunction

    task automatic random_phase(int n);
        repeat (n) send_req(rand_req());
        drain();
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        i_valid    = 1'b0;
        i_data     = '0;
        no_gaps    = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed part at reset settings
        send_req(mk_req(asmc_pkg::REQ_STEP, 0, 0, 0, 0));
        send_req(mk_req(asmc_pkg::REQ_STEP, 32'sh8000_0000, 32'sh8000_0000,
                        32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        send_req(mk_req(asmc_pkg::REQ_STEP, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                        32'sh8000_0000, 32'sh8000_0000));
        send_req(mk_req(asmc_pkg::REQ_STEP, 0, 0, 0, 6554));
        send_req(mk_req(asmc_pkg::REQ_STEP, 0, 0, 0, -6554));
        send_req(mk_req(asmc_pkg::REQ_STEP, 0, 0, 0, 6553));
        send_req(mk_req(asmc_pkg::REQ_RESET, 32'sh7FFF_FFFF, -1, 5, 7));
        send_req(mk_req(asmc_pkg::REQ_STEP, 0, 0, 65536, 0));
        send_req(mk_req(asmc_pkg::REQ_STEP, 0, 0, 0, 0));
        send_req(mk_req(asmc_pkg::REQ_STEP, 100, -5, 100, -5));
        drain();
        write_reg(asmc_pkg::REG_ANGULAR_MODE, 31'd1);
        send_req(mk_req(asmc_pkg::REQ_STEP, 0, 0, 205887, 0));
        send_req(mk_req(asmc_pkg::REQ_STEP, 0, 0, 205888, 0));
        send_req(mk_req(asmc_pkg::REQ_STEP, 0, 0, -205887, 0));
        send_req(mk_req(asmc_pkg::REQ_STEP, 0, 0, -205888, 0));
        send_req(mk_req(asmc_pkg::REQ_STEP, 0, 0, 0, 205888));
        send_req(mk_req(asmc_pkg::REQ_STEP, 0, 205888, 0, 0));
        send_req(mk_req(asmc_pkg::REQ_STEP, 32'sh8000_0000, 0, 32'sh7FFF_FFFF, 0));
        send_req(mk_req(asmc_pkg::REQ_STEP, 32'sh7FFF_FFFF, 0, 32'sh8000_0000, 0));
        send_req(mk_req(asmc_pkg::REQ_RESET, 0, 0, 0, 0));
        send_req(mk_req(asmc_pkg::REQ_STEP, 0, 0, 0, 0));
        drain();

        // random traffic over several settings, extremes among them
        write_all(31'd655, 31'd65536, 31'd65536, 31'd65536, 31'd65536, 31'd6554,
                  31'd6554, 31'd0);
        random_phase(400);
        write_all(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                  31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        random_phase(250);
        write_all(31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0);
        random_phase(250);
        write_all(31'd65536, 31'd131072, 31'd32768, 31'd2000000, 31'd300000,
                  31'd65536, 31'd6554, 31'd1);
        no_gaps = 1'b1;
        random_phase(300);
        no_gaps = 1'b0;
        repeat (4) begin
            write_all(31'($urandom_range(0, 1 << 17)), 31'($urandom_range(0, 1 << 19)),
                      31'($urandom_range(0, 1 << 19)), 31'($urandom_range(0, 1 << 22)),
                      31'($urandom_range(0, 1 << 20)), 31'($urandom_range(0, 1 << 17)),
                      31'($urandom_range(0, 1 << 17)), 31'($urandom));
            random_phase(200);
        end

        if (fail_count == 0 && pending == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
